// ----- sv/frame_packet_ring_manager_defines.svh -----
// Assertion macros shared by the frame and packet ring manager RTL
`ifndef FRAME_PACKET_RING_MANAGER_DEFINES_SVH
`define FRAME_PACKET_RING_MANAGER_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during reset
`define FPRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset
`define FPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fprm_pkg.sv -----
// Shared constants, codes and control types of the frame and packet ring manager
package fprm_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LEN_BITS = OFFSET_BITS + 1;
	localparam int FRAME_SLOTS_DEF = 16;
	localparam int PACKET_SLOTS_DEF = 64;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_FS_BITS = 5;
	localparam int CFG_PS_BITS = 7;

	localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFER_SIZE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_SLOTS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PACKET_SLOTS = 2'd2;

	localparam logic [LEN_BITS-1:0] CFG_BS_RESET = LEN_BITS'(1) << OFFSET_BITS;
	localparam logic [CFG_FS_BITS-1:0] CFG_FS_RESET = 5'd16;
	localparam logic [CFG_PS_BITS-1:0] CFG_PS_RESET = 7'd64;

	localparam logic [2:0] MODE_FRAME_CHK = 3'd0;
	localparam logic [2:0] MODE_PKT_CHK = 3'd1;
	localparam logic [2:0] MODE_INSERT = 3'd2;
	localparam logic [2:0] MODE_CLOSE = 3'd3;
	localparam logic [2:0] MODE_READ = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_NORM,
		OP_FAIL,
		OP_RD_BASE,
		OP_RD_PKT,
		OP_RD_CLOSE,
		OP_RD_FRAME,
		OP_LD_BASE,
		OP_DIST,
		OP_STEP,
		OP_COMMIT,
		OP_LD_PW,
		OP_INSERT,
		OP_LD_CLOSE,
		OP_CDIST,
		OP_CLOSE_A,
		OP_CLOSE_B,
		OP_READ,
		OP_HREAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       oversize;
		logic       over;
		logic       step_fail;
		logic       skip;
	} dp_stat_t;

endpackage

// ----- sv/frame_packet_ring_manager.sv -----
// Top level of the frame and packet ring manager: controller, datapath and checks
// One request at a time: raise start while busy is low; busy rises at the next edge and one
// result follows, shown for a single cycle with done high. The receiver cannot stall, so
// capture the result in that cycle. Done ends every request: one refused as oversize or
// unknown, a read, an insert, a close, and a room check that steps back over k slots,
// whether it then fits or fails; busy falls in the cycle after done. The room checks are
// bounded by the step-back loop, which reads one frame or packet descriptor per step
// through the single read port of each descriptor store. Configuration writes are always
// taken (cfg_ready is high) and belong between requests.
`include "frame_packet_ring_manager_defines.svh"

module frame_packet_ring_manager #(
	parameter int FRAME_SLOTS = fprm_pkg::FRAME_SLOTS_DEF,
	parameter int PACKET_SLOTS = fprm_pkg::PACKET_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         mode,
	input  logic [fprm_pkg::LEN_BITS-1:0]      length,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [fprm_pkg::OFFSET_BITS-1:0]   address,
	output logic [fprm_pkg::LEN_BITS-1:0]      byte_count,
	output logic [fprm_pkg::LEN_BITS-1:0]      first_part,
	output logic [fprm_pkg::LEN_BITS-1:0]      head_length,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fprm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [fprm_pkg::LEN_BITS-1:0]      cfg_data
);
	import fprm_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fprm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	fprm_dp #(
		.FRAME_SLOTS  (FRAME_SLOTS),
		.PACKET_SLOTS (PACKET_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.length      (length),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.address     (address),
		.byte_count  (byte_count),
		.first_part  (first_part),
		.head_length (head_length)
	);

	`FPRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`FPRM_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a request")
	`FPRM_ASSERT_NEXT(a_done_once, done, !done && !busy, "result strobe not a single pulse")
	`FPRM_ASSERT_NOW(a_fail_clean, done && status != ST_OK, address == '0 && byte_count == '0 && first_part == '0, "failed request returned data")

endmodule

// ----- sv/fprm_ctrl.sv -----
// Sequencing state machine of the frame and packet ring manager
module fprm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fprm_pkg::dp_stat_t stat,
	output fprm_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import fprm_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_NORM   = 15'b000000000000010,
		S_DECIDE = 15'b000000000000100,
		S_LDB    = 15'b000000000001000,
		S_DIST   = 15'b000000000010000,
		S_TEST   = 15'b000000000100000,
		S_INS1   = 15'b000000001000000,
		S_INS2   = 15'b000000010000000,
		S_CL1    = 15'b000000100000000,
		S_CL2    = 15'b000001000000000,
		S_CL3    = 15'b000010000000000,
		S_CL4    = 15'b000100000000000,
		S_RDF    = 15'b001000000000000,
		S_HREAD  = 15'b010000000000000,
		S_DONE   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_ACCEPT;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cmd.op = OP_NORM;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if ((stat.mode <= MODE_INSERT && stat.oversize) || stat.mode > MODE_READ) begin
					cmd.op = OP_FAIL;
					state_d = S_HREAD;
				end else begin
					case (stat.mode)
						MODE_FRAME_CHK, MODE_PKT_CHK: begin
							cmd.op = OP_RD_BASE;
							state_d = S_LDB;
						end
						MODE_INSERT: begin
							cmd.op = OP_RD_PKT;
							state_d = S_INS1;
						end
						MODE_CLOSE: begin
							cmd.op = OP_RD_CLOSE;
							state_d = S_CL1;
						end
						default: begin
							cmd.op = OP_RD_FRAME;
							state_d = S_RDF;
						end
					endcase
				end
			end
			S_LDB: begin
				cmd.op = OP_LD_BASE;
				state_d = S_DIST;
			end
			S_DIST: begin
				cmd.op = OP_DIST;
				state_d = S_TEST;
			end
			S_TEST: begin
				// step back while the request overruns unread data
				if (stat.over) begin
					if (stat.step_fail) begin
						cmd.op = OP_FAIL;
						state_d = S_HREAD;
					end else begin
						cmd.op = OP_STEP;
						state_d = S_DIST;
					end
				end else begin
					if (stat.skip) cmd.op = OP_COMMIT;
					state_d = S_HREAD;
				end
			end
			S_INS1: begin
				cmd.op = OP_LD_PW;
				state_d = S_INS2;
			end
			S_INS2: begin
				cmd.op = OP_INSERT;
				state_d = S_HREAD;
			end
			S_CL1: begin
				cmd.op = OP_LD_CLOSE;
				state_d = S_CL2;
			end
			S_CL2: begin
				cmd.op = OP_CDIST;
				state_d = S_CL3;
			end
			S_CL3: begin
				cmd.op = OP_CLOSE_A;
				state_d = S_CL4;
			end
			S_CL4: begin
				cmd.op = OP_CLOSE_B;
				state_d = S_HREAD;
			end
			S_RDF: begin
				cmd.op = OP_READ;
				state_d = S_HREAD;
			end
			S_HREAD: begin
				cmd.op = OP_HREAD;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ----- sv/fprm_dp.sv -----
// Descriptor stores, slot indices, configuration and arithmetic of the ring manager
module fprm_dp #(
	parameter int FRAME_SLOTS = fprm_pkg::FRAME_SLOTS_DEF,
	parameter int PACKET_SLOTS = fprm_pkg::PACKET_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fprm_pkg::dp_cmd_t                  cmd,
	output fprm_pkg::dp_stat_t                 stat,
	input  logic [2:0]                         mode,
	input  logic [fprm_pkg::LEN_BITS-1:0]      length,
	input  logic                               cfg_we,
	input  logic [fprm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [fprm_pkg::LEN_BITS-1:0]      cfg_data,
	output logic [1:0]                         status,
	output logic [fprm_pkg::OFFSET_BITS-1:0]   address,
	output logic [fprm_pkg::LEN_BITS-1:0]      byte_count,
	output logic [fprm_pkg::LEN_BITS-1:0]      first_part,
	output logic [fprm_pkg::LEN_BITS-1:0]      head_length
);
	import fprm_pkg::*;

	localparam int OB = OFFSET_BITS;
	localparam int LW = LEN_BITS;
	localparam int FIW = $clog2(FRAME_SLOTS);
	localparam int FSW = $clog2(FRAME_SLOTS + 1);
	localparam int FCW = (FSW > CFG_FS_BITS) ? FSW : CFG_FS_BITS;
	localparam int PIW = $clog2(PACKET_SLOTS);
	localparam int PSW = $clog2(PACKET_SLOTS + 1);
	localparam int PCW = (PSW > CFG_PS_BITS) ? PSW : CFG_PS_BITS;
	localparam logic [LW-1:0] BS_CAP = LW'(1) << OB;

	function automatic logic [OB-1:0] off_f(input logic [OB-1:0] x, input logic [LW-1:0] b);
		return ({1'b0, x} < b) ? x : '0;
	endfunction

	function automatic logic [LW-1:0] dist_f(input logic [OB-1:0] a, input logic [OB-1:0] c,
			input logic [LW-1:0] b);
		logic [LW:0] t;
		t = {2'b0, a} + ((a < c) ? {1'b0, b} : '0) - {2'b0, c};
		return t[LW-1:0];
	endfunction

	function automatic logic [LW-1:0] first_f(input logic [OB-1:0] st, input logic [LW-1:0] n,
			input logic [LW-1:0] b);
		logic [LW:0] e;
		e = {2'b0, st} + {1'b0, n};
		return (e <= {1'b0, b}) ? n : b - {1'b0, st};
	endfunction

	// configuration
	logic [LW-1:0] bs_cfg_q;
	logic [CFG_FS_BITS-1:0] fs_cfg_q;
	logic [CFG_PS_BITS-1:0] ps_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_cfg_q <= CFG_BS_RESET;
			fs_cfg_q <= CFG_FS_RESET;
			ps_cfg_q <= CFG_PS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUFFER_SIZE: bs_cfg_q <= cfg_data;
				CFG_FRAME_SLOTS: fs_cfg_q <= cfg_data[CFG_FS_BITS-1:0];
				CFG_PACKET_SLOTS: ps_cfg_q <= cfg_data[CFG_PS_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [LW-1:0] bs;
	logic [FCW-1:0] fs_ext;
	logic [PCW-1:0] ps_ext;
	logic [FSW-1:0] fs;
	logic [PSW-1:0] ps;

	always_comb begin
		bs = (bs_cfg_q == '0) ? LW'(1) : ((bs_cfg_q > BS_CAP) ? BS_CAP : bs_cfg_q);
		fs_ext = FCW'(fs_cfg_q);
		ps_ext = PCW'(ps_cfg_q);
		fs = FSW'((fs_ext < FCW'(2)) ? FCW'(2) :
			((fs_ext > FCW'(FRAME_SLOTS)) ? FCW'(FRAME_SLOTS) : fs_ext));
		ps = PSW'((ps_ext < PCW'(2)) ? PCW'(2) :
			((ps_ext > PCW'(PACKET_SLOTS)) ? PCW'(PACKET_SLOTS) : ps_ext));
	end

	// control registers
	logic [FIW-1:0] wr_q, rd_q, w_q;
	logic [PIW-1:0] pk_q, s_q;
	logic skip_q;

	// payload registers
	logic [2:0] mode_q;
	logic [LW-1:0] len_q;
	logic [OB-1:0] pr_q, cur_q;
	logic [LW-1:0] dist_q;
	logic [1:0] status_q;
	logic [OB-1:0] addr_q;
	logic [LW-1:0] cnt_q, first_q;

	// descriptor stores
	logic [OB-1:0] fstart_mem [FRAME_SLOTS];
	logic [LW-1:0] flen_mem [FRAME_SLOTS];
	logic [OB-1:0] pstart_mem [PACKET_SLOTS];
	logic [FRAME_SLOTS-1:0] fs_vld_q, fl_vld_q;
	logic [PACKET_SLOTS-1:0] pk_vld_q;
	logic [OB-1:0] fs_rdata_q, pk_rdata_q;
	logic [LW-1:0] fl_rdata_q;
	logic fs_rvld_q, fl_rvld_q, pk_rvld_q;

	logic [OB-1:0] fdata, pdata;
	logic [LW-1:0] fldata;
	assign fdata = fs_rvld_q ? fs_rdata_q : '0;
	assign fldata = fl_rvld_q ? fl_rdata_q : '0;
	assign pdata = pk_rvld_q ? pk_rdata_q : '0;

	logic frame_mode;
	logic [FIW-1:0] w_nx, wr_inc, rd_inc;
	logic [PIW-1:0] s_nx, pk_inc;
	logic [OB-1:0] cur_off, dist_in;
	logic [LW-1:0] dist_w;
	logic [LW:0] ins_sum;
	logic ins_wrap;
	logic [LW-1:0] ins_first;
	logic [OB-1:0] ins_nxt;
	logic [OB-1:0] rd_st;
	logic rd_empty;
	logic [LW-1:0] rd_first, cl_first;

	always_comb begin
		frame_mode = (mode_q == MODE_FRAME_CHK);
		w_nx = (w_q == '0) ? FIW'(fs - FSW'(1)) : w_q - 1'b1;
		s_nx = s_q - 1'b1;
		wr_inc = (FSW'(wr_q) + FSW'(1) >= fs) ? '0 : wr_q + 1'b1;
		rd_inc = (FSW'(rd_q) + FSW'(1) >= fs) ? '0 : rd_q + 1'b1;
		pk_inc = (PSW'(pk_q) + PSW'(1) >= ps) ? '0 : pk_q + 1'b1;
		cur_off = off_f(frame_mode ? fdata : pdata, bs);
		dist_in = (cmd.op == OP_DIST) ? cur_off : cur_q;
		dist_w = dist_f(dist_in, pr_q, bs);
		ins_sum = {2'b0, pr_q} + {1'b0, len_q};
		ins_wrap = (ins_sum >= {1'b0, bs});
		ins_first = ins_wrap ? bs - {1'b0, pr_q} : len_q;
		ins_nxt = ins_wrap ? OB'(ins_sum - {1'b0, bs}) : OB'(ins_sum);
		rd_st = off_f(fdata, bs);
		rd_empty = (rd_q == wr_q) || (fldata == '0);
		rd_first = first_f(rd_st, fldata, bs);
		cl_first = first_f(pr_q, dist_q, bs);
	end

	assign stat.mode = mode_q;
	assign stat.oversize = (len_q > bs);
	assign stat.over = ({1'b0, dist_q} + {1'b0, len_q}) > {1'b0, bs};
	assign stat.step_fail = frame_mode ? (w_nx == rd_q) : (s_q <= PIW'(1));
	assign stat.skip = skip_q;

	// memory addresses and write strobes
	logic [FIW-1:0] f_ra, fs_wa, fl_wa;
	logic [PIW-1:0] p_ra, pk_wa;
	logic fs_we, fl_we, pk_we, pk_clr;
	logic [LW-1:0] fl_wd;
	logic [OB-1:0] pk_wd;

	always_comb begin
		case (cmd.op)
			OP_LD_BASE: f_ra = w_q;
			OP_STEP: f_ra = w_nx;
			OP_RD_CLOSE: f_ra = wr_q;
			default: f_ra = rd_q;
		endcase
		case (cmd.op)
			OP_LD_BASE: p_ra = s_q;
			OP_STEP: p_ra = s_nx;
			default: p_ra = pk_q;
		endcase
		fs_we = (cmd.op == OP_CLOSE_B);
		fs_wa = wr_inc;
		fl_we = 1'b0;
		fl_wa = rd_q;
		fl_wd = '0;
		pk_we = 1'b0;
		pk_clr = 1'b0;
		pk_wa = '0;
		pk_wd = cur_q;
		case (cmd.op)
			OP_COMMIT: begin
				if (frame_mode) begin
					fl_we = 1'b1;
					fl_wa = w_q;
					pk_we = 1'b1;
					pk_clr = 1'b1;
				end
			end
			OP_CLOSE_A: begin
				fl_we = 1'b1;
				fl_wa = wr_q;
				fl_wd = dist_q;
			end
			OP_CLOSE_B: begin
				fl_we = 1'b1;
				fl_wa = wr_inc;
				pk_we = 1'b1;
				pk_clr = 1'b1;
			end
			OP_READ: begin
				fl_we = !rd_empty;
			end
			OP_INSERT: begin
				pk_we = 1'b1;
				pk_wa = pk_inc;
				pk_wd = ins_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fs_we) fstart_mem[fs_wa] <= cur_q;
		if (fl_we) flen_mem[fl_wa] <= fl_wd;
		if (pk_we) pstart_mem[pk_wa] <= pk_wd;
		fs_rdata_q <= fstart_mem[f_ra];
		fl_rdata_q <= flen_mem[f_ra];
		pk_rdata_q <= pstart_mem[p_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_vld_q <= '0;
			fl_vld_q <= '0;
			pk_vld_q <= '0;
			fs_rvld_q <= 1'b0;
			fl_rvld_q <= 1'b0;
			pk_rvld_q <= 1'b0;
		end else begin
			if (fs_we) fs_vld_q[fs_wa] <= 1'b1;
			if (fl_we) fl_vld_q[fl_wa] <= 1'b1;
			// a new frame drops every packet start but the first
			if (pk_clr) pk_vld_q <= PACKET_SLOTS'(1);
			else if (pk_we) pk_vld_q[pk_wa] <= 1'b1;
			fs_rvld_q <= fs_vld_q[f_ra];
			fl_rvld_q <= fl_vld_q[f_ra];
			pk_rvld_q <= pk_vld_q[p_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			pk_q <= '0;
			w_q <= '0;
			s_q <= '0;
			skip_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_NORM: begin
					if (FSW'(wr_q) >= fs) wr_q <= '0;
					if (FSW'(rd_q) >= fs) rd_q <= '0;
					if (PSW'(pk_q) >= ps) pk_q <= '0;
					skip_q <= 1'b0;
				end
				OP_RD_BASE: begin
					w_q <= wr_q;
					s_q <= pk_q;
				end
				OP_STEP: begin
					skip_q <= 1'b1;
					if (frame_mode) w_q <= w_nx;
					else s_q <= s_nx;
				end
				OP_COMMIT: begin
					if (frame_mode) begin
						wr_q <= w_q;
						pk_q <= '0;
					end else begin
						pk_q <= s_q;
					end
				end
				OP_INSERT: pk_q <= pk_inc;
				OP_CLOSE_B: begin
					wr_q <= wr_inc;
					pk_q <= '0;
				end
				OP_READ: begin
					if (!rd_empty) rd_q <= rd_inc;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				mode_q <= mode;
				len_q <= length;
			end
			OP_NORM: begin
				status_q <= ST_OK;
				addr_q <= '0;
				cnt_q <= '0;
				first_q <= '0;
			end
			OP_FAIL: status_q <= ST_NO_ROOM;
			OP_LD_BASE: pr_q <= off_f(fdata, bs);
			OP_DIST: begin
				cur_q <= cur_off;
				dist_q <= dist_w;
			end
			OP_LD_PW: pr_q <= off_f(pdata, bs);
			OP_INSERT: begin
				addr_q <= pr_q;
				cnt_q <= len_q;
				first_q <= ins_first;
			end
			OP_LD_CLOSE: begin
				pr_q <= off_f(fdata, bs);
				cur_q <= off_f(pdata, bs);
			end
			OP_CDIST: dist_q <= dist_w;
			OP_CLOSE_A: begin
				addr_q <= pr_q;
				cnt_q <= dist_q;
				first_q <= cl_first;
			end
			OP_READ: begin
				if (rd_empty) begin
					status_q <= ST_EMPTY;
				end else begin
					addr_q <= rd_st;
					cnt_q <= fldata;
					first_q <= rd_first;
				end
			end
			default: ;
		endcase
	end

	assign status = status_q;
	assign address = addr_q;
	assign byte_count = cnt_q;
	assign first_part = first_q;
	assign head_length = fldata;

endmodule
